// ===== rtl/psa_pkg.sv =====
// ----------------------------------------------------------------------------
// psa_pkg
// Shared constants, types and codes of the palette slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package psa_pkg;

  localparam int unsigned Slots         = 16;
  localparam int unsigned ColorsPerSlot = 16;
  localparam int unsigned UseCountBits  = 16;
  localparam int unsigned TotalColors   = Slots * ColorsPerSlot;
  localparam int unsigned MaxWords      = TotalColors / 2;
  localparam int unsigned WordsPerSlot  = ColorsPerSlot / 2;
  localparam int unsigned SlotW         = $clog2(Slots);
  localparam int unsigned AddrW         = $clog2(MaxWords);
  localparam int unsigned WcntW         = $clog2(MaxWords + 2);
  localparam int unsigned SpanW         = $clog2(Slots + 1);
  localparam int unsigned WofsW         = $clog2(WordsPerSlot);

  typedef logic [2:0] op_t;
  localparam op_t OpFind4   = 3'd0;
  localparam op_t OpCreate4 = 3'd1;
  localparam op_t OpFind8   = 3'd2;
  localparam op_t OpCreate8 = 3'd3;
  localparam op_t OpAddRef  = 3'd4;
  localparam op_t OpRelease = 3'd5;

  typedef logic [1:0] status_t;
  localparam status_t StOk      = 2'd0;
  localparam status_t StMiss    = 2'd1;
  localparam status_t StBadLen  = 2'd2;

  typedef struct packed {
    op_t               op;
    logic [SlotW-1:0]  slot_id;
    logic [31:0]       color_word;
    logic              last;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [SlotW-1:0]  slot_index;
    logic [4:0]        used_slots;
  } rsp_t;

  typedef enum logic [3:0] {
    StIdle,
    StDecide,
    StHashChk,
    StCmpRd,
    StCmp,
    StScanNext,
    StCreate,
    StCopy,
    StRelease,
    StSum,
    StRespond
  } fsm_e;

endpackage

`default_nettype wire

// ===== rtl/psa_if.sv =====
// ----------------------------------------------------------------------------
// psa_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface psa_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/psa_ram.sv =====
// ----------------------------------------------------------------------------
// psa_ram
// Generic single-write, single-read synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module psa_ram #(
  parameter int unsigned Depth = 128,
  parameter int unsigned Width = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/palette_slot_allocator_core.sv =====
// ----------------------------------------------------------------------------
// palette_slot_allocator_core
// Palette slot allocator: 16 reference-counted slots, stored palettes in RAM.
// ----------------------------------------------------------------------------
// Palette words stream into a request RAM at one per cycle while the core is
// idle and no result waits; the word marked last (or an add-reference/release
// op) starts a sequencer that works over the slot table one slot per cycle
// outside compares and compares stored words one per cycle through the color
// RAM's single read port. A compare or copy covers up to 128 words, and a
// top-down find may compare once per slot. The used-slot total is summed over
// the 16 slots before each result. The result sits in an output register;
// new input waits until it is taken.
`default_nettype none

module palette_slot_allocator_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  psa_stream_if.sink   in_if,
  psa_stream_if.source out_if
);

  localparam int unsigned S  = psa_pkg::Slots;
  localparam int unsigned SW = psa_pkg::SlotW;
  localparam int unsigned AW = psa_pkg::AddrW;
  localparam int unsigned CW = psa_pkg::WcntW;
  localparam int unsigned PW = psa_pkg::SpanW;
  localparam int unsigned UW = psa_pkg::UseCountBits;
  localparam logic [UW-1:0] CntMax = {UW{1'b1}};

  psa_pkg::req_t req;
  assign req = in_if.data;

  // slot table
  logic [UW-1:0] cnt_q  [S];
  logic          lock_q [S];
  logic          wide_q [S];
  logic [PW-1:0] span_q [S];
  logic [31:0]   hash_q [S];
  logic          reg_q  [S];

  psa_pkg::fsm_e state_q, state_d;
  logic [CW-1:0] wcnt_q;
  psa_pkg::op_t  pop_q;
  logic [31:0]   hacc_q;
  logic [SW-1:0] sid_q;
  logic [SW:0]   idx_q;       // scan index, one wider for down-count end
  logic [PW-1:0] run_q;
  logic [PW-1:0] need_q;
  logic [CW-1:0] nw_q;        // word count of closed request
  logic [AW:0]   wi_q;        // word pointer for compare/copy
  logic          mis_q;
  logic          hsel_q;      // in hash-check phase of find
  logic [SW-1:0] hslot_q;
  logic [31:0]   rhash_q;
  logic [4:0]    sum_q;
  psa_pkg::rsp_t rsp_q;
  logic          ovalid_q;

  // request RAM
  logic          rq_we;
  logic [AW-1:0] rq_ra;
  logic [31:0]   rq_rd;
  psa_ram #(.Depth(psa_pkg::MaxWords), .Width(32)) u_req_ram (
    .clk_i(clk_i), .we_i(rq_we), .waddr_i(wcnt_q[AW-1:0]),
    .wdata_i(req.color_word), .raddr_i(rq_ra), .rdata_o(rq_rd)
  );

  // color RAM
  logic          cs_we;
  logic [AW-1:0] cs_wa, cs_ra;
  logic [31:0]   cs_rd;
  psa_ram #(.Depth(psa_pkg::MaxWords), .Width(32)) u_col_ram (
    .clk_i(clk_i), .we_i(cs_we), .waddr_i(cs_wa),
    .wdata_i(rq_rd), .raddr_i(cs_ra), .rdata_o(cs_rd)
  );

  logic in_acc;
  assign in_acc = in_if.valid && in_if.ready;
  assign in_if.ready = (state_q == psa_pkg::StIdle) && !ovalid_q;
  assign out_if.valid = ovalid_q;
  assign out_if.data  = rsp_q;

  logic [SW-1:0] cur;
  assign cur = idx_q[SW-1:0];

  logic [AW-1:0] base;
  assign base = AW'({cur, {psa_pkg::WofsW{1'b0}}});

  // wide span and first narrow slot
  logic [PW-1:0] wspan;
  assign wspan = (cnt_q[0] != '0 && wide_q[0]) ? span_q[0] : '0;
  logic [PW-1:0] fnarrow;
  always_comb begin
    fnarrow = PW'(S);
    for (int i = S - 1; i >= 0; i--) begin
      if (cnt_q[i] != '0 && !wide_q[i]) fnarrow = PW'(i);
    end
  end
  // first slot holding the request hash
  logic          hhit;
  logic [SW-1:0] hidx;
  always_comb begin
    hhit = 1'b0;
    hidx = '0;
    for (int i = S - 1; i >= 0; i--) begin
      if (reg_q[i] && hash_q[i] == rhash_q) begin
        hhit = 1'b1;
        hidx = SW'(i);
      end
    end
  end

  logic len_ok;
  logic [CW-1:0] nw_new;
  assign nw_new = (wcnt_q <= CW'(psa_pkg::MaxWords)) ? wcnt_q + 1'b1 : wcnt_q;
  assign len_ok = (nw_q <= CW'(psa_pkg::MaxWords)) && (nw_q != '0)
                  && (nw_q[psa_pkg::WofsW-1:0] == '0);

  logic match_ok;   // header check for narrow compare on cur
  assign match_ok = cnt_q[cur] != '0 && !wide_q[cur]
                    && {span_q[cur], {psa_pkg::WofsW{1'b0}}} == (PW + psa_pkg::WofsW)'(nw_q);

  // words of the compare/copy
  logic [AW-1:0] wi_lo;
  assign wi_lo = wi_q[AW-1:0];
  assign rq_ra = wi_lo;
  assign cs_ra = base + wi_lo;
  assign cs_wa = base + AW'(wi_q - 1'b1);
  assign rq_we = in_acc && (wcnt_q < CW'(psa_pkg::MaxWords)) &&
                 (wcnt_q != '0 || req.op < psa_pkg::OpAddRef);
  assign cs_we = (state_q == psa_pkg::StCopy) && wi_q != '0;

  logic wi_end;
  assign wi_end = (wi_q == (AW + 1)'(nw_q));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      psa_pkg::StIdle:     if (in_acc && (wcnt_q == '0 && req.op >= psa_pkg::OpAddRef))
                             state_d = psa_pkg::StRelease;
                           else if (in_acc && req.last) state_d = psa_pkg::StDecide;
      psa_pkg::StDecide:   state_d = psa_pkg::StHashChk;
      psa_pkg::StHashChk:  state_d = psa_pkg::StScanNext;
      psa_pkg::StScanNext: state_d = psa_pkg::StScanNext;
      psa_pkg::StCmpRd:    state_d = psa_pkg::StCmp;
      psa_pkg::StCmp:      state_d = psa_pkg::StCmp;
      psa_pkg::StCreate:   state_d = psa_pkg::StCopy;
      psa_pkg::StCopy:     state_d = wi_end ? psa_pkg::StSum : psa_pkg::StCopy;
      psa_pkg::StRelease:  state_d = psa_pkg::StSum;
      psa_pkg::StSum:      state_d = (idx_q == (SW + 1)'(S - 1)) ? psa_pkg::StRespond
                                                                 : psa_pkg::StSum;
      psa_pkg::StRespond:  state_d = psa_pkg::StIdle;
      default:             state_d = psa_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= psa_pkg::StIdle;
      wcnt_q   <= '0;
      pop_q    <= psa_pkg::OpFind4;
      ovalid_q <= 1'b0;
      for (int i = 0; i < S; i++) begin
        cnt_q[i]  <= '0;
        lock_q[i] <= 1'b0;
        wide_q[i] <= 1'b0;
        span_q[i] <= '0;
        hash_q[i] <= '0;
        reg_q[i]  <= 1'b0;
      end
    end else begin
      state_q <= state_d;
      if (out_if.valid && out_if.ready) ovalid_q <= 1'b0;
      unique case (state_q)
        psa_pkg::StIdle: begin
          if (in_acc) begin
            if (wcnt_q == '0 && req.op >= psa_pkg::OpAddRef) begin
              pop_q <= req.op;
              sid_q <= req.slot_id;
            end else begin
              if (wcnt_q == '0) begin
                pop_q  <= req.op;
                hacc_q <= 32'(2) + req.color_word;
              end else if (wcnt_q < CW'(4)) begin
                hacc_q <= hacc_q + 32'(2) + req.color_word;
              end else begin
                hacc_q <= hacc_q + 32'(2);
              end
              if (req.last) begin
                wcnt_q <= '0;
                nw_q   <= nw_new;
              end else begin
                wcnt_q <= nw_new;
              end
            end
          end
        end
        psa_pkg::StDecide: begin
          rhash_q <= hacc_q;
          need_q  <= PW'(nw_q >> psa_pkg::WofsW);
          sid_q   <= '0;
          run_q   <= '0;
          idx_q   <= (SW + 1)'(S - 1);
          wi_q    <= '0;
          hsel_q  <= 1'b0;
        end
        psa_pkg::StHashChk: begin
          state_q <= psa_pkg::StScanNext;
          if (!len_ok) begin
            rsp_q.status <= psa_pkg::StBadLen;
            rsp_q.slot_index <= '0;
            idx_q <= '0;
            state_q <= psa_pkg::StSum;
          end else if (pop_q == psa_pkg::OpFind8) begin
            if (wspan >= need_q) begin
              if (cnt_q[0] != CntMax) cnt_q[0] <= cnt_q[0] + 1'b1;
              rsp_q.status <= psa_pkg::StOk;
            end else rsp_q.status <= psa_pkg::StMiss;
            rsp_q.slot_index <= '0;
            idx_q <= '0;
            state_q <= psa_pkg::StSum;
          end else if (pop_q == psa_pkg::OpCreate8) begin
            rsp_q.slot_index <= '0;
            idx_q <= '0;
            state_q <= psa_pkg::StSum;
            if (cnt_q[0] != '0 && !wide_q[0]) begin
              rsp_q.status <= psa_pkg::StMiss;
            end else if (wspan >= need_q) begin
              if (cnt_q[0] != CntMax) cnt_q[0] <= cnt_q[0] + 1'b1;
              rsp_q.status <= psa_pkg::StOk;
            end else if (need_q > fnarrow) begin
              rsp_q.status <= psa_pkg::StMiss;
            end else begin
              if (cnt_q[0] != '0) begin
                if (cnt_q[0] != CntMax) cnt_q[0] <= cnt_q[0] + 1'b1;
              end else begin
                cnt_q[0]  <= UW'(1);
                wide_q[0] <= 1'b1;
                hash_q[0] <= '0;
                reg_q[0]  <= 1'b0;
              end
              span_q[0] <= need_q;
              for (int k = 0; k < S; k++) begin
                if (PW'(k) < need_q) lock_q[k] <= 1'b1;
              end
              rsp_q.status <= psa_pkg::StOk;
              idx_q <= '0;
              state_q <= psa_pkg::StCopy;
            end
          end else if (pop_q == psa_pkg::OpFind4 && hhit) begin
            hsel_q  <= 1'b1;
            hslot_q <= hidx;
            idx_q   <= {1'b0, hidx};
            state_q <= psa_pkg::StCmpRd;
          end
        end
        psa_pkg::StScanNext: begin
          // idx_q counts down; below limit means done
          if (idx_q[SW] || idx_q < (SW + 1)'(wspan)) begin
            rsp_q.status <= psa_pkg::StMiss;
            rsp_q.slot_index <= '0;
            idx_q <= '0;
            state_q <= psa_pkg::StSum;
          end else if (pop_q == psa_pkg::OpFind4) begin
            if (match_ok) begin
              wi_q <= '0;
              state_q <= psa_pkg::StCmpRd;
            end else idx_q <= idx_q - 1'b1;
          end else begin
            if (cnt_q[cur] != '0 || lock_q[cur]) begin
              run_q <= '0;
              idx_q <= idx_q - 1'b1;
            end else if (run_q + 1'b1 == need_q) begin
              state_q <= psa_pkg::StCreate;
            end else begin
              run_q <= run_q + 1'b1;
              idx_q <= idx_q - 1'b1;
            end
          end
        end
        psa_pkg::StCmpRd: begin
          if (!match_ok) begin
            // hash hit failed header check: fall to scan
            hsel_q  <= 1'b0;
            idx_q   <= (SW + 1)'(S - 1);
            state_q <= psa_pkg::StScanNext;
          end else begin
            mis_q <= 1'b0;
            wi_q  <= wi_q + 1'b1;
          end
        end
        psa_pkg::StCmp: begin
          // data of word wi_q-1 is on the RAM outputs
          if (cs_rd != rq_rd || wi_end) begin
            if (cs_rd == rq_rd) begin
              if (cnt_q[cur] != CntMax) cnt_q[cur] <= cnt_q[cur] + 1'b1;
              rsp_q.status <= psa_pkg::StOk;
              rsp_q.slot_index <= cur;
              idx_q <= '0;
              state_q <= psa_pkg::StSum;
            end else if (hsel_q) begin
              hsel_q  <= 1'b0;
              wi_q    <= '0;
              idx_q   <= (SW + 1)'(S - 1);
              state_q <= psa_pkg::StScanNext;
            end else begin
              wi_q    <= '0;
              idx_q   <= idx_q - 1'b1;
              state_q <= psa_pkg::StScanNext;
            end
          end else begin
            wi_q <= wi_q + 1'b1;
          end
        end
        psa_pkg::StCreate: begin
          cnt_q[cur]  <= UW'(1);
          wide_q[cur] <= 1'b0;
          hash_q[cur] <= rhash_q;
          span_q[cur] <= need_q;
          for (int k = 0; k < S; k++) begin
            if (reg_q[k] && hash_q[k] == rhash_q) reg_q[k] <= 1'b0;
            if (SW'(k) >= cur && (PW + 1)'(k) < (PW + 1)'(cur) + (PW + 1)'(need_q))
              lock_q[k] <= 1'b1;
          end
          reg_q[cur] <= 1'b1;
          rsp_q.status <= psa_pkg::StOk;
          rsp_q.slot_index <= cur;
          wi_q <= '0;
        end
        psa_pkg::StCopy: begin
          wi_q <= wi_q + 1'b1;
          if (wi_end) idx_q <= '0;
        end
        psa_pkg::StRelease: begin
          idx_q <= '0;
          rsp_q.slot_index <= '0;
          rsp_q.status <= psa_pkg::StMiss;
          if (cnt_q[sid_q] != '0 && pop_q <= psa_pkg::OpRelease) begin
            rsp_q.status <= psa_pkg::StOk;
            rsp_q.slot_index <= sid_q;
            if (pop_q == psa_pkg::OpAddRef) begin
              if (cnt_q[sid_q] != CntMax) cnt_q[sid_q] <= cnt_q[sid_q] + 1'b1;
            end else if (cnt_q[sid_q] != UW'(1)) begin
              cnt_q[sid_q] <= cnt_q[sid_q] - 1'b1;
            end else begin
              for (int k = 0; k < S; k++) begin
                if (SW'(k) >= sid_q &&
                    (PW + 1)'(k) < (PW + 1)'(sid_q) + (PW + 1)'(span_q[sid_q]))
                  lock_q[k] <= 1'b0;
                if (!wide_q[sid_q] && reg_q[k] && hash_q[k] == hash_q[sid_q])
                  reg_q[k] <= 1'b0;
              end
              cnt_q[sid_q]  <= '0;
              wide_q[sid_q] <= 1'b0;
              span_q[sid_q] <= '0;
              hash_q[sid_q] <= '0;
              reg_q[sid_q]  <= 1'b0;
            end
          end
        end
        psa_pkg::StSum: begin
          if (idx_q == '0) sum_q <= (cnt_q[0] != '0) ? 5'(span_q[0]) : '0;
          else if (cnt_q[cur] != '0) sum_q <= sum_q + 5'(span_q[cur]);
          idx_q <= idx_q + 1'b1;
        end
        psa_pkg::StRespond: begin
          rsp_q.used_slots <= sum_q;
          ovalid_q <= 1'b1;
        end
        default: ;
      endcase
      if (state_q == psa_pkg::StCmpRd && match_ok) state_q <= psa_pkg::StCmp;
    end
  end

endmodule

`default_nettype wire
